FILE: src/gc_pkg.sv
package gc_pkg;

    localparam int NODE_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CNT_W   = 9;
    localparam int COLORS  = 256;
    localparam int ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef struct packed {
        logic [CNT_W-1:0]   colors_used;
        logic [COLOR_W-1:0] color;
        logic [NODE_W-1:0]  node;
    } res_t;

endpackage

FILE: src/gc_ram.sv
module gc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/gc_seq.sv
module gc_seq #(
    parameter int NODES = 256,
    localparam int IW = $clog2(NODES)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [gc_pkg::CNT_W-1:0]  node_count,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [gc_pkg::ACT_W-1:0]  action,
    input  logic [gc_pkg::NODE_W-1:0] node_a,
    input  logic [gc_pkg::NODE_W-1:0] node_b,
    output logic                      res_valid,
    input  logic                      res_take,
    output gc_pkg::res_t              res
);

    typedef enum logic [4:0] {
        S_IDLE, S_E1, S_E2, S_E3, S_E4, S_RD1, S_RD2,
        S_DEG_RD, S_DEG_LD, S_DEG_CNT, S_VS_RD, S_VS_CHK,
        S_CL_RD, S_CL_LD, S_CL_ISS, S_CL_WAIT, S_FREE, S_DONE, S_OUT
    } state_t;

    localparam int CW = gc_pkg::CNT_W;

    state_t                      state_reg;
    gc_pkg::action_t             act;
    logic [gc_pkg::NODE_W-1:0]   a_reg, b_reg;
    logic [CW-1:0]               n_reg, n_eff;
    logic [CW-1:0]               i_reg, j_reg, k_reg, d_reg;
    logic [CW-1:0]               cnt_reg, maxdeg_reg, top_reg, total_reg;
    logic [gc_pkg::COLOR_W-1:0]  c_reg, color_reg;
    logic [NODES-1:0]            valid_reg, colored_reg, row_reg;
    logic [gc_pkg::COLORS-1:0]   taken_reg;
    logic [IW-1:0]               adj_addr_reg;

    logic [NODES-1:0]            adj_rdata, row_eff, adj_wdata;
    logic                        adj_we, deg_we, col_we;
    logic [CW-1:0]               deg_rdata;
    logic [gc_pkg::COLOR_W-1:0]  col_rdata;
    logic [IW-1:0]               col_raddr;
    logic                        a_ok, b_ok;
    logic [CW-1:0]               k_inc, i_inc, c_plus;
    logic                        k_wrap, free_hit;

    assign act    = gc_pkg::action_t'(action);
    assign n_eff  = (node_count > CW'(NODES)) ? CW'(NODES) : node_count;
    assign a_ok   = {1'b0, node_a} < CW'(NODES);
    assign b_ok   = {1'b0, node_b} < CW'(NODES);
    assign row_eff = valid_reg[adj_addr_reg] ? adj_rdata : '0;
    assign adj_we = (state_reg == S_E2) || (state_reg == S_E4);
    assign adj_wdata = row_eff | (NODES'(1) << ((state_reg == S_E2) ?
                       b_reg[IW-1:0] : a_reg[IW-1:0]));
    assign deg_we = (state_reg == S_DEG_CNT) && (j_reg == n_reg);
    assign k_inc  = k_reg + CW'(1);
    assign i_inc  = i_reg + CW'(1);
    assign k_wrap = (k_inc == n_reg);
    assign c_plus = {1'b0, c_reg} + CW'(1);
    assign free_hit = !taken_reg[c_reg] || (c_reg == gc_pkg::COLOR_W'(gc_pkg::COLORS - 1));
    assign col_we = (state_reg == S_FREE) && free_hit;
    assign col_raddr = (state_reg == S_RD1) ? a_reg[IW-1:0] : j_reg[IW-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res.node        = a_reg;
    assign res.color       = color_reg;
    assign res.colors_used = total_reg;

    gc_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_addr_reg), .wdata(adj_wdata),
        .raddr(adj_addr_reg), .rdata(adj_rdata)
    );

    gc_ram #(.WIDTH(CW), .DEPTH(NODES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(i_reg[IW-1:0]), .wdata(cnt_reg),
        .raddr(k_reg[IW-1:0]), .rdata(deg_rdata)
    );

    gc_ram #(.WIDTH(gc_pkg::COLOR_W), .DEPTH(NODES)) u_col (
        .clk(clk), .we(col_we), .waddr(k_reg[IW-1:0]), .wdata(c_reg),
        .raddr(col_raddr), .rdata(col_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            colored_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg <= node_a;
                        b_reg <= node_b;
                        unique case (act)
                            gc_pkg::ACT_CLEAR:
                            begin
                                valid_reg   <= '0;
                                colored_reg <= '0;
                                total_reg   <= '0;
                            end
                            gc_pkg::ACT_EDGE:
                            begin
                                if (a_ok && b_ok && node_a != node_b)
                                begin
                                    adj_addr_reg <= node_a[IW-1:0];
                                    state_reg    <= S_E1;
                                end
                            end
                            gc_pkg::ACT_RUN:
                            begin
                                n_reg        <= n_eff;
                                colored_reg  <= '0;
                                i_reg        <= '0;
                                top_reg      <= '0;
                                maxdeg_reg   <= '0;
                                adj_addr_reg <= '0;
                                state_reg    <= (n_eff == '0) ? S_DONE : S_DEG_RD;
                            end
                            gc_pkg::ACT_READ:
                            begin
                                color_reg <= '0;
                                if (a_ok && colored_reg[node_a[IW-1:0]])
                                    state_reg <= S_RD1;
                                else
                                    state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_E1: state_reg <= S_E2;
                S_E2:
                begin
                    valid_reg[adj_addr_reg] <= 1'b1;
                    adj_addr_reg <= b_reg[IW-1:0];
                    state_reg    <= S_E3;
                end
                S_E3: state_reg <= S_E4;
                S_E4:
                begin
                    valid_reg[adj_addr_reg] <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_RD1: state_reg <= S_RD2;
                S_RD2:
                begin
                    color_reg <= col_rdata;
                    state_reg <= S_OUT;
                end
                S_DEG_RD: state_reg <= S_DEG_LD;
                S_DEG_LD:
                begin
                    row_reg   <= row_eff;
                    j_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DEG_CNT;
                end
                S_DEG_CNT:
                begin
                    if (j_reg != n_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(row_reg[j_reg[IW-1:0]]);
                        j_reg   <= j_reg + CW'(1);
                    end
                    else
                    begin
                        i_reg        <= i_inc;
                        adj_addr_reg <= i_inc[IW-1:0];
                        if (i_inc == n_reg)
                        begin
                            k_reg     <= '0;
                            d_reg     <= (cnt_reg > maxdeg_reg) ? cnt_reg : maxdeg_reg;
                            state_reg <= S_VS_RD;
                        end
                        else
                        begin
                            if (cnt_reg > maxdeg_reg)
                                maxdeg_reg <= cnt_reg;
                            state_reg <= S_DEG_RD;
                        end
                    end
                end
                S_VS_RD: state_reg <= S_VS_CHK;
                S_VS_CHK, S_FREE:
                begin
                    if (state_reg == S_VS_CHK && deg_rdata == d_reg)
                    begin
                        adj_addr_reg <= k_reg[IW-1:0];
                        state_reg    <= S_CL_RD;
                    end
                    else if (state_reg == S_FREE && !free_hit)
                    begin
                        c_reg <= c_reg + gc_pkg::COLOR_W'(1);
                    end
                    else
                    begin
                        if (state_reg == S_FREE)
                        begin
                            colored_reg[k_reg[IW-1:0]] <= 1'b1;
                            if (c_plus > top_reg)
                                top_reg <= c_plus;
                        end
                        // next node in this degree level, or drop one level
                        if (!k_wrap)
                        begin
                            k_reg     <= k_inc;
                            state_reg <= S_VS_RD;
                        end
                        else if (d_reg == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            d_reg     <= d_reg - CW'(1);
                            k_reg     <= '0;
                            state_reg <= S_VS_RD;
                        end
                    end
                end
                S_CL_RD: state_reg <= S_CL_LD;
                S_CL_LD:
                begin
                    row_reg   <= row_eff;
                    taken_reg <= '0;
                    j_reg     <= '0;
                    state_reg <= S_CL_ISS;
                end
                S_CL_ISS:
                begin
                    if (j_reg == n_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_FREE;
                    end
                    else if (row_reg[j_reg[IW-1:0]] && colored_reg[j_reg[IW-1:0]])
                        state_reg <= S_CL_WAIT;
                    else
                        j_reg <= j_reg + CW'(1);
                end
                S_CL_WAIT:
                begin
                    taken_reg[col_rdata] <= 1'b1;
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= S_CL_ISS;
                end
                S_DONE:
                begin
                    total_reg <= top_reg;
                    a_reg     <= '0;
                    color_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_take)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && act == gc_pkg::ACT_CLEAR) |=>
        (valid_reg == '0 && colored_reg == '0 && total_reg == '0))
        else $error("clear did not empty the graph");

    a_all_colored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ($countones(colored_reg) == int'(n_reg)))
        else $error("run ended with uncolored active nodes");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (total_reg <= n_reg))
        else $error("more colors than active nodes");

endmodule

FILE: src/greedy_graph_coloring.sv
// Clear empties the graph. Add edge: two row read-modify-writes on the matrix RAM.
// Read color returns a colored node's color. A coloring run over n active nodes counts
// each node's degree, then scans the nodes in degree order from the max degree D down,
// giving each the lowest color that its colored neighbours leave free.
// One transaction in flight; a finished result waits in the output register.
// rst_n (async, low) empties the graph via row valid bits and sets node_count to 256.
module greedy_graph_coloring #(
    parameter int MAX_NODES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // node_a[7:0], node_b[15:8]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // node[7:0], color[15:8], colors_used[24:16]
);

    localparam int NODES = (MAX_NODES < 256) ? MAX_NODES : 256;

    logic [gc_pkg::CNT_W-1:0] node_count_reg;
    logic                     out_valid_reg;
    gc_pkg::res_t             out_data_reg;
    gc_pkg::res_t             res;
    logic                     res_valid, res_take;

    assign res_take = !out_valid_reg || m_axis_tready;

    gc_seq #(.NODES(NODES)) u_seq (
        .clk(clk), .rst_n(rst_n), .node_count(node_count_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tuser), .node_a(s_axis_tdata[7:0]), .node_b(s_axis_tdata[15:8]),
        .res_valid(res_valid), .res_take(res_take), .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= gc_pkg::CNT_W'(256);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_count_reg <= cfg_wdata;
            if (res_valid && res_take)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg.colors_used, out_data_reg.color,
                            out_data_reg.node};

endmodule
